// ===== rtl/isle_pkg.sv =====
package isle_pkg;

   localparam int CAPACITY    = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int WORD_W      = 32;
   localparam int POS_W       = 7;
   localparam int ADDR_W      = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic signed [WORD_W-1:0]      word_type;
   typedef logic        [ADDR_W-1:0]      addr_type;
   typedef logic        [CNT_W-1:0]       cnt_type;
   typedef logic        [CMP_W-1:0]       cmp_type;
   typedef logic        [POS_W-1:0]       pos_type;
   typedef logic signed [POS_W-1:0]       index_type;

   typedef enum logic [3:0] {
      OP_PUSH_BACK  = 4'd0,
      OP_PUSH_FRONT = 4'd1,
      OP_INSERT_AT  = 4'd2,
      OP_POP_BACK   = 4'd3,
      OP_POP_FRONT  = 4'd4,
      OP_REMOVE_AT  = 4'd5,
      OP_CONTAINS   = 4'd6,
      OP_GET_AT     = 4'd7,
      OP_INDEX_OF   = 4'd8,
      OP_LENGTH     = 4'd9
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_BAD_INDEX = 2'd1,
      STAT_EMPTY     = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

endpackage

// ===== rtl/indexed_sequence_list_engine_core.sv =====
// Ordered list of up to CAPACITY signed values with a length count.
//
// Request channel (req_valid/req_ready): req_type picks push back, push
// front, insert at, pop back, pop front, remove at, contains, get at,
// index of, or length; req_item_value and req_position carry the operands.
// Result channel (rsp_valid/rsp_ready): one item per request with the
// fetched or removed value, found flag, first match index (-1 if absent),
// length after the operation and a status (ok, bad index, empty, full).
//
// One request is in work at a time; req_ready is high only while idle.
// Elements live in a single memory with one write port and one registered
// read port, and every shift or search step moves one element per cycle.
// A finished result sits in the output register, so the next request is
// accepted while it waits; if the receiver stalls, the following result
// holds in the done state until the output register frees up.
// Reset empties the list and drops any pending result; the memory itself
// is not cleared, since only entries below the length are ever read.
module indexed_sequence_list_engine_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [3:0]               req_type,
   input  logic signed [31:0]       req_item_value,
   input  logic [6:0]               req_position,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [31:0]       rsp_result_value,
   output logic                     rsp_found,
   output logic signed [6:0]        rsp_found_index,
   output logic [6:0]               rsp_length_now,
   output logic [1:0]               rsp_status
);

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_INS_SHIFT = 9'b000000010,
      S_INS_FILL  = 9'b000000100,
      S_REM_READ  = 9'b000001000,
      S_REM_SHIFT = 9'b000010000,
      S_GET_READ  = 9'b000100000,
      S_GET_CAP   = 9'b001000000,
      S_SRCH      = 9'b010000000,
      S_DONE      = 9'b100000000
   } state_type;

   // Element memory and its registered read port
   isle_pkg::value_type element_store [isle_pkg::CAPACITY];
   isle_pkg::value_type rd_data_ff;

   state_type              state_ff, state_in;
   isle_pkg::cnt_type      count_ff, count_in;
   isle_pkg::cnt_type      ptr_ff, ptr_in;
   isle_pkg::addr_type     at_ff, at_in;
   isle_pkg::value_type    val_ff, val_in;
   logic                   wb_valid_ff, wb_valid_in;
   isle_pkg::addr_type     wb_addr_ff, wb_addr_in;
   logic                   chk_valid_ff, chk_valid_in;
   isle_pkg::addr_type     chk_idx_ff, chk_idx_in;
   isle_pkg::word_type     res_value_ff, res_value_in;
   logic                   res_found_ff, res_found_in;
   isle_pkg::index_type    res_index_ff, res_index_in;
   isle_pkg::status_type   res_status_ff, res_status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_load;
   isle_pkg::word_type     rsp_value_ff;
   logic                   rsp_found_ff;
   isle_pkg::index_type    rsp_index_ff;
   isle_pkg::pos_type      rsp_length_ff;
   isle_pkg::status_type   rsp_status_ff;

   logic                   rd_en;
   isle_pkg::addr_type     rd_addr;
   logic                   wr_en;
   isle_pkg::addr_type     wr_addr;
   isle_pkg::value_type    wr_data;

   isle_pkg::op_type       op;
   isle_pkg::cmp_type      count_cmp;
   isle_pkg::cmp_type      ins_at;
   isle_pkg::cmp_type      rem_at;
   isle_pkg::cnt_type      ptr_inc;
   isle_pkg::cnt_type      ptr_dec;
   isle_pkg::word_type     rd_word;

   assign op        = isle_pkg::op_type'(req_type);
   assign count_cmp = isle_pkg::cmp_type'(count_ff);
   assign ptr_inc   = ptr_ff + 1'b1;
   assign ptr_dec   = ptr_ff - 1'b1;
   // Sign-extend or cut the stored width to the result word
   assign rd_word   = isle_pkg::word_type'(rd_data_ff);

   // Target position of an insert or a remove, before range checks
   always_comb begin
      unique case (op)
         isle_pkg::OP_PUSH_BACK:  ins_at = count_cmp;
         isle_pkg::OP_PUSH_FRONT: ins_at = '0;
         default:                 ins_at = isle_pkg::cmp_type'(req_position);
      endcase
      unique case (op)
         isle_pkg::OP_POP_BACK:   rem_at = count_cmp - 1'b1;
         isle_pkg::OP_POP_FRONT:  rem_at = '0;
         default:                 rem_at = isle_pkg::cmp_type'(req_position);
      endcase
   end

   // Single write port: either a shifted element or the inserted value
   assign wr_en   = wb_valid_ff | (state_ff == S_INS_FILL);
   assign wr_addr = (state_ff == S_INS_FILL) ? at_ff : wb_addr_ff;
   assign wr_data = (state_ff == S_INS_FILL) ? val_ff : rd_data_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      at_in         = at_ff;
      val_in        = val_ff;
      wb_valid_in   = 1'b0;
      wb_addr_in    = wb_addr_ff;
      chk_valid_in  = 1'b0;
      chk_idx_in    = chk_idx_ff;
      res_value_in  = res_value_ff;
      res_found_in  = res_found_ff;
      res_index_in  = res_index_ff;
      res_status_in = res_status_ff;
      rd_en         = 1'b0;
      rd_addr       = at_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_value_in  = '0;
               res_found_in  = 1'b0;
               res_index_in  = '1;
               res_status_in = isle_pkg::STAT_OK;
               state_in      = S_DONE;
               val_in        = isle_pkg::value_type'(req_item_value);
               unique case (op)
                  isle_pkg::OP_PUSH_BACK, isle_pkg::OP_PUSH_FRONT,
                  isle_pkg::OP_INSERT_AT: begin
                     // Index check comes before the full check
                     if (ins_at > count_cmp) begin
                        res_status_in = isle_pkg::STAT_BAD_INDEX;
                     end else if (count_ff >= isle_pkg::cnt_type'(isle_pkg::CAPACITY)) begin
                        res_status_in = isle_pkg::STAT_FULL;
                     end else begin
                        at_in    = ins_at[isle_pkg::ADDR_W-1:0];
                        ptr_in   = count_ff;
                        state_in = S_INS_SHIFT;
                     end
                  end
                  isle_pkg::OP_POP_BACK, isle_pkg::OP_POP_FRONT,
                  isle_pkg::OP_REMOVE_AT, isle_pkg::OP_GET_AT: begin
                     if (count_ff == '0) begin
                        res_status_in = isle_pkg::STAT_EMPTY;
                     end else if (rem_at >= count_cmp) begin
                        res_status_in = isle_pkg::STAT_BAD_INDEX;
                     end else begin
                        at_in    = rem_at[isle_pkg::ADDR_W-1:0];
                        ptr_in   = isle_pkg::cnt_type'(rem_at[isle_pkg::ADDR_W-1:0]);
                        state_in = (op == isle_pkg::OP_GET_AT) ? S_GET_READ : S_REM_READ;
                     end
                  end
                  isle_pkg::OP_CONTAINS, isle_pkg::OP_INDEX_OF: begin
                     ptr_in   = '0;
                     state_in = S_SRCH;
                  end
                  default: begin
                     // Length and undefined codes report the count only
                  end
               endcase
            end
         end
         S_INS_SHIFT: begin
            // Walk down from the end, moving element ptr-1 to ptr
            if (ptr_ff > isle_pkg::cnt_type'(at_ff)) begin
               rd_en       = 1'b1;
               rd_addr     = ptr_dec[isle_pkg::ADDR_W-1:0];
               wb_valid_in = 1'b1;
               wb_addr_in  = ptr_ff[isle_pkg::ADDR_W-1:0];
               ptr_in      = ptr_dec;
            end else begin
               state_in = S_INS_FILL;
            end
         end
         S_INS_FILL: begin
            count_in = count_ff + 1'b1;
            state_in = S_DONE;
         end
         S_REM_READ: begin
            rd_en    = 1'b1;
            rd_addr  = at_ff;
            state_in = S_REM_SHIFT;
         end
         S_REM_SHIFT: begin
            // First pass holds the removed element on the read port
            if (ptr_ff == isle_pkg::cnt_type'(at_ff)) begin
               res_value_in = rd_word;
            end
            if (ptr_inc < count_ff) begin
               rd_en       = 1'b1;
               rd_addr     = ptr_inc[isle_pkg::ADDR_W-1:0];
               wb_valid_in = 1'b1;
               wb_addr_in  = ptr_ff[isle_pkg::ADDR_W-1:0];
               ptr_in      = ptr_inc;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end
         end
         S_GET_READ: begin
            rd_en    = 1'b1;
            rd_addr  = at_ff;
            state_in = S_GET_CAP;
         end
         S_GET_CAP: begin
            res_value_in = rd_word;
            state_in     = S_DONE;
         end
         S_SRCH: begin
            // Compare uses the registered read data and index; stop at the first match
            if (chk_valid_ff && (rd_data_ff == val_ff)) begin
               res_found_in = 1'b1;
               res_index_in = isle_pkg::index_type'(chk_idx_ff);
               state_in     = S_DONE;
            end else if (ptr_ff < count_ff) begin
               rd_en        = 1'b1;
               rd_addr      = ptr_ff[isle_pkg::ADDR_W-1:0];
               chk_valid_in = 1'b1;
               chk_idx_in   = ptr_ff[isle_pkg::ADDR_W-1:0];
               ptr_in       = ptr_inc;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         element_store[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= element_store[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         wb_valid_ff  <= 1'b0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wb_valid_ff  <= wb_valid_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      at_ff         <= at_in;
      val_ff        <= val_in;
      wb_addr_ff    <= wb_addr_in;
      chk_idx_ff    <= chk_idx_in;
      res_value_ff  <= res_value_in;
      res_found_ff  <= res_found_in;
      res_index_ff  <= res_index_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_value_ff  <= res_value_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_index_ff  <= res_index_ff;
         rsp_length_ff <= isle_pkg::pos_type'(count_ff);
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_found_index  = rsp_index_ff;
   assign rsp_length_now   = rsp_length_ff;
   assign rsp_status       = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= isle_pkg::cnt_type'(isle_pkg::CAPACITY))
      else $error("element count above capacity");

   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(wb_valid_ff && (state_ff == S_INS_FILL)))
      else $error("shift write-back collides with insert fill");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |->
         ($past(state_ff) == S_INS_FILL || $past(state_ff) == S_REM_SHIFT))
      else $error("element count changed outside insert or remove");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> ($past(state_ff) == S_DONE))
      else $error("result raised without a finished request");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   // Expected contents of one result item.
   typedef struct packed {
      isle_pkg::word_type   value;
      logic                 found;
      isle_pkg::index_type  index;
      isle_pkg::pos_type    length;
      isle_pkg::status_type status;
   } list_result_type;

   // Operation mix used by the random phases.
   typedef enum {BIAS_GROW, BIAS_SHRINK, BIAS_EVEN} op_bias_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [3:0]          req_type;
   isle_pkg::word_type  req_item_value;
   isle_pkg::pos_type   req_position;
   logic                rsp_valid;
   logic                rsp_ready;
   isle_pkg::word_type  rsp_result_value;
   logic                rsp_found;
   isle_pkg::index_type rsp_found_index;
   isle_pkg::pos_type   rsp_length_now;
   logic [1:0]          rsp_status;

   // Shadow copy of the list, advanced once per accepted item.
   isle_pkg::value_type list_store [isle_pkg::CAPACITY];
   int                  list_len;
   list_result_type     pending_results [$];
   int                  errors;
   bit                  steady_flow;

   indexed_sequence_list_engine_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_item_value   (req_item_value),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_found        (rsp_found),
      .rsp_found_index  (rsp_found_index),
      .rsp_length_now   (rsp_length_now),
      .rsp_status       (rsp_status)
   );

   always #2 clock = ~clock;

   // Apply one operation to the shadow list and return the item it must produce.
   function automatic list_result_type apply_list_op(input logic [3:0] code,
                                                     input isle_pkg::word_type val,
                                                     input isle_pkg::pos_type pos);
      list_result_type     res;
      isle_pkg::value_type entry;
      int                  at;
      entry      = isle_pkg::value_type'(val);
      res.value  = '0;
      res.found  = 1'b0;
      res.index  = '1;
      res.status = isle_pkg::STAT_OK;
      unique case (code)
         isle_pkg::OP_PUSH_BACK, isle_pkg::OP_PUSH_FRONT, isle_pkg::OP_INSERT_AT: begin
            at = (code == isle_pkg::OP_PUSH_BACK) ? list_len :
                 (code == isle_pkg::OP_PUSH_FRONT) ? 0 : int'(pos);
            // index check wins over the full check
            if (at > list_len)
               res.status = isle_pkg::STAT_BAD_INDEX;
            else if (list_len >= isle_pkg::CAPACITY)
               res.status = isle_pkg::STAT_FULL;
            else begin
               for (int i = list_len; i > at; i--)
                  list_store[i] = list_store[i - 1];
               list_store[at] = entry;
               list_len++;
            end
         end
         isle_pkg::OP_POP_BACK, isle_pkg::OP_POP_FRONT, isle_pkg::OP_REMOVE_AT,
         isle_pkg::OP_GET_AT: begin
            at = (code == isle_pkg::OP_POP_BACK) ? list_len - 1 :
                 (code == isle_pkg::OP_POP_FRONT) ? 0 : int'(pos);
            if (list_len == 0)
               res.status = isle_pkg::STAT_EMPTY;
            else if (at >= list_len)
               res.status = isle_pkg::STAT_BAD_INDEX;
            else begin
               res.value = isle_pkg::word_type'(list_store[at]);
               if (code != isle_pkg::OP_GET_AT) begin
                  for (int i = at; i + 1 < list_len; i++)
                     list_store[i] = list_store[i + 1];
                  list_len--;
               end
            end
         end
         isle_pkg::OP_CONTAINS, isle_pkg::OP_INDEX_OF: begin
            for (int i = 0; i < list_len; i++)
               if (!res.found && list_store[i] == entry) begin
                  res.found = 1'b1;
                  res.index = isle_pkg::index_type'(i);
               end
         end
         default: ;
      endcase
      res.length = isle_pkg::pos_type'(list_len);
      return res;
   endfunction

   // Mostly short gaps, a few long ones, none while steady_flow holds.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Favor values that are likely to be in the list so searches hit.
   function automatic isle_pkg::word_type pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20 && list_len > 0)
         return isle_pkg::word_type'(list_store[$urandom_range(0, list_len - 1)]);
      if (r < 40)
         return isle_pkg::word_type'($urandom_range(0, 7)) - 3;
      if (r < 48)
         return (r[0]) ? 32'sh7fff_ffff : 32'sh8000_0000;
      return isle_pkg::word_type'($urandom);
   endfunction

   function automatic isle_pkg::pos_type pick_position();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return isle_pkg::pos_type'($urandom_range(0, list_len));
      if (r < 90)
         return isle_pkg::pos_type'($urandom_range(0, 127));
      return isle_pkg::pos_type'(list_len + 1);
   endfunction

   function automatic logic [3:0] pick_op(input op_bias_type bias);
      int r;
      int grow_lim;
      int shrink_lim;
      r = $urandom_range(0, 99);
      unique case (bias)
         BIAS_GROW:   begin grow_lim = 62; shrink_lim = 77; end
         BIAS_SHRINK: begin grow_lim = 17; shrink_lim = 77; end
         default:     begin grow_lim = 37; shrink_lim = 62; end
      endcase
      if (r < 2)
         return 4'($urandom_range(15, int'(isle_pkg::OP_LENGTH) + 1));
      if (r < grow_lim)
         return 4'($urandom_range(int'(isle_pkg::OP_PUSH_BACK),
                                  int'(isle_pkg::OP_INSERT_AT)));
      if (r < shrink_lim)
         return 4'($urandom_range(int'(isle_pkg::OP_POP_BACK),
                                  int'(isle_pkg::OP_REMOVE_AT)));
      return 4'($urandom_range(int'(isle_pkg::OP_CONTAINS), int'(isle_pkg::OP_LENGTH)));
   endfunction

   // Present one item, hold it until accepted, then record what it must produce.
   task automatic send_item(input logic [3:0] code, input isle_pkg::word_type val,
                            input isle_pkg::pos_type pos);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= code;
      req_item_value <= val;
      req_position   <= pos;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      pending_results.push_back(apply_list_op(code, val, pos));
   endtask

   // Drop valid and hold until every outstanding item has come back.
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_random_items(input int count, input op_bias_type bias);
      logic [3:0] code;
      for (int n = 0; n < count; n++) begin
         code = pick_op(bias);
         send_item(code, pick_value(), pick_position());
      end
   endtask

   task automatic test_directed_edges();
      // empty list: every removal and fetch reports empty
      send_item(isle_pkg::OP_POP_BACK, 0, 0);
      send_item(isle_pkg::OP_POP_FRONT, 0, 0);
      send_item(isle_pkg::OP_REMOVE_AT, 0, 0);
      send_item(isle_pkg::OP_GET_AT, 0, 0);
      send_item(isle_pkg::OP_CONTAINS, 0, 0);
      send_item(isle_pkg::OP_INDEX_OF, -1, 0);
      send_item(isle_pkg::OP_LENGTH, 0, 0);
      send_item(isle_pkg::OP_INSERT_AT, 5, 1);
      send_item(4'(int'(isle_pkg::OP_LENGTH) + 1), 0, 0);
      // small list with extreme values
      send_item(isle_pkg::OP_PUSH_BACK, 32'sh7fff_ffff, 0);
      send_item(isle_pkg::OP_PUSH_FRONT, 32'sh8000_0000, 0);
      send_item(isle_pkg::OP_INSERT_AT, -1, 1);
      send_item(isle_pkg::OP_INSERT_AT, 0, 3);
      send_item(isle_pkg::OP_CONTAINS, -1, 0);
      send_item(isle_pkg::OP_INDEX_OF, 12345, 0);
      send_item(isle_pkg::OP_GET_AT, 0, 0);
      // a position equal to the length is out of range
      send_item(isle_pkg::OP_GET_AT, 0, 4);
      send_item(isle_pkg::OP_GET_AT, 0, 127);
      send_item(isle_pkg::OP_REMOVE_AT, 0, 4);
      send_item(isle_pkg::OP_REMOVE_AT, 0, 1);
      send_item(isle_pkg::OP_POP_FRONT, 0, 0);
      send_item(isle_pkg::OP_POP_BACK, 0, 0);
      send_item(isle_pkg::OP_LENGTH, 0, 0);
      send_item(4'hF, 32'shffff_ffff, 127);
      send_item(isle_pkg::OP_INSERT_AT, 9, 127);
      wait_for_results();
   endtask

   // Mostly inserts: reach capacity and keep pushing against it.
   task automatic test_grow_to_full();
      run_random_items(300, BIAS_GROW);
      wait_for_results();
   endtask

   // Mostly removals: run the list back down to empty.
   task automatic test_drain_to_empty();
      run_random_items(300, BIAS_SHRINK);
      wait_for_results();
   endtask

   // Even mix, with one stretch of back-to-back traffic on both sides.
   task automatic test_mixed_traffic();
      for (int chunk = 0; chunk < 4; chunk++) begin
         steady_flow = (chunk == 2);
         run_random_items(160, BIAS_EVEN);
         wait_for_results();
      end
      steady_flow = 1'b0;
   endtask

   // Result side: ready in random runs, with stalls of random length.
   initial begin : rsp_pacer
      int gap;
      rsp_ready = 1'b0;
      while (reset !== 1'b0)
         @(negedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   task automatic report_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : result_checker
      list_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result item with nothing pending", $time);
            errors++;
         end else begin
            want = pending_results.pop_front();
            report_field("result_value", want.value, rsp_result_value);
            report_field("found", 32'(want.found), 32'(rsp_found));
            report_field("found_index", 32'(want.index), 32'(rsp_found_index));
            report_field("length_now", 32'(want.length), 32'(rsp_length_now));
            report_field("status", 32'(want.status), 32'(rsp_status));
         end
      end
   end

   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = '0;
      req_item_value = '0;
      req_position   = '0;
      list_len       = 0;
      errors         = 0;
      steady_flow    = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_grow_to_full();
      test_drain_to_empty();
      test_mixed_traffic();

      wait_for_results();
      // let any stray item surface before the verdict
      repeat (100) @(posedge clock);
      if (pending_results.size() != 0)
         $display("%0t: %0d expected items never arrived", $time, pending_results.size());
      if (errors == 0 && pending_results.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
